// ===== hdl/fskd_pkg.sv =====
`timescale 1ns / 1ps

package fskd_pkg;

	localparam int MAX_SLOTS    = 256;
	localparam int SECTOR_BYTES = 4096;

	localparam int SLOT_AW = $clog2(MAX_SLOTS);
	localparam int CNT_W   = SLOT_AW + 1;
	localparam int KEY_W   = 16;
	localparam int ADDR_W  = 32;
	localparam int LOG2_W  = 4;
	localparam int LEN_W   = 13;
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 3;
	localparam int ENT_W   = 2;
	localparam int CFG_IW  = 2;

	localparam logic [LOG2_W-1:0] LOG2_MIN = LOG2_W'(2);
	localparam logic [LOG2_W-1:0] LOG2_MAX = LOG2_W'($clog2(SECTOR_BYTES) > 12 ?
		12 : $clog2(SECTOR_BYTES));

	localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ERASE     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ERASE_ALL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ_IDX  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_CREATED   = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd3;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd4;
	localparam logic [STAT_W-1:0] ST_DONE      = 3'd5;

	localparam logic [ENT_W-1:0] ENT_FREE  = 2'd0;
	localparam logic [ENT_W-1:0] ENT_VALID = 2'd1;
	localparam logic [ENT_W-1:0] ENT_DEAD  = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_BASE  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_LOG2  = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_COUNT = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [KEY_W-1:0]   search_key;
		logic [LEN_W-1:0]   payload_length;
		logic               auto_create;
		logic [SLOT_AW-1:0] slot_number;
	} fskd_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SLOT_AW-1:0] slot_index;
		logic [ADDR_W-1:0]  byte_address;
		logic               free_slot_valid;
		logic [SLOT_AW-1:0] free_slot;
	} fskd_rsp_t;

	typedef struct packed {
		logic start;
		logic scan_en;
		logic commit;
	} fskd_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_hit;
		logic scan_done;
		logic out_free;
	} fskd_sts_t;

	function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] l);
		logic [LOG2_W-1:0] r;
		r = l;
		if (r < LOG2_MIN) r = LOG2_MIN;
		if (r > LOG2_MAX) r = LOG2_MAX;
		return r;
	endfunction

endpackage

// ===== hdl/fskd_ctrl.sv =====
`timescale 1ns / 1ps

module fskd_ctrl import fskd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  fskd_sts_t sts,
	output fskd_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;

	assign req_stall   = (state_q != S_IDLE);
	assign cmd.start   = req_valid && (state_q == S_IDLE);
	assign cmd.scan_en = (state_q == S_SCAN);
	assign cmd.commit  = (state_q == S_FIN) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) state_q <= sts.need_scan ? S_SCAN : S_FIN;
				end
				S_SCAN: begin
					if (sts.scan_hit || sts.scan_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/fskd_dp.sv =====
`timescale 1ns / 1ps

module fskd_dp import fskd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [ADDR_W-1:0]   cfg_wdata,
	input  fskd_req_t           req,
	output fskd_rsp_t           rsp,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  fskd_cmd_t           cmd,
	output fskd_sts_t           sts
);

	logic [ADDR_W-1:0] base_q;
	logic [LOG2_W-1:0] log2_q;
	logic [CNT_W-1:0]  count_q;

	logic [LOG2_W-1:0] lg;
	logic [CNT_W-1:0]  cnt_eff;
	logic [LEN_W-1:0]  slot_bytes;

	fskd_req_t req_q;

	// directory: {state, key}; an entry whose valid bit is clear reads as free
	logic [ENT_W+KEY_W-1:0] mem_q [MAX_SLOTS];
	logic [MAX_SLOTS-1:0]   vld_q;
	logic [ENT_W+KEY_W-1:0] rd_s1;
	logic                   ent_vld_s1;

	logic [CNT_W-1:0]   addr_q;
	logic               issue;
	logic               chk_vld_s1;
	logic [SLOT_AW-1:0] chk_idx_s1;
	logic [ENT_W-1:0]   ent_st;
	logic               hit_now;
	logic               free_now;

	logic               ff_vld_q;
	logic [SLOT_AW-1:0] ff_q;
	logic               hit_vld_q;
	logic [SLOT_AW-1:0] hit_q;

	fskd_rsp_t          rsp_q;
	fskd_rsp_t          rsp_n;
	logic               rsp_valid_q;
	logic [SLOT_AW-1:0] sel_idx;
	logic               use_addr;
	logic               too_large;
	logic               mem_we;
	logic [SLOT_AW-1:0] mem_waddr;
	logic [ENT_W-1:0]   mem_wst;

	assign lg         = eff_log2(log2_q);
	assign cnt_eff    = (count_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : count_q;
	assign slot_bytes = LEN_W'(1) << lg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			log2_q  <= LOG2_W'(8);
			count_q <= CNT_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE:  base_q  <= cfg_wdata;
				CFG_LOG2:  log2_q  <= cfg_wdata[LOG2_W-1:0];
				CFG_COUNT: count_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign sts.need_scan = (cnt_eff != '0) &&
		((req.kind == KIND_LOOKUP) || (req.kind == KIND_ERASE) ||
		((req.kind == KIND_WRITE) && (req.payload_length <= slot_bytes)));

	assign issue    = (addr_q < cnt_eff);
	assign ent_st   = ent_vld_s1 ? rd_s1[ENT_W+KEY_W-1:KEY_W] : ENT_FREE;
	assign hit_now  = cmd.scan_en && chk_vld_s1 && (ent_st == ENT_VALID) &&
		(rd_s1[KEY_W-1:0] == req_q.search_key);
	assign free_now = cmd.scan_en && chk_vld_s1 && (ent_st == ENT_FREE) && !ff_vld_q;

	assign sts.scan_hit  = hit_now;
	assign sts.scan_done = !chk_vld_s1 && !issue;
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= {mem_wst, req_q.search_key};
		rd_s1      <= mem_q[addr_q[SLOT_AW-1:0]];
		ent_vld_s1 <= vld_q[addr_q[SLOT_AW-1:0]];
		if (cmd.start) begin
			req_q <= req;
			ff_q  <= '0;
			hit_q <= '0;
		end else begin
			if (free_now) ff_q <= chk_idx_s1;
			if (hit_now) hit_q <= chk_idx_s1;
		end
		chk_idx_s1 <= addr_q[SLOT_AW-1:0];
		if (cmd.commit) rsp_q <= rsp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			chk_vld_s1  <= 1'b0;
			ff_vld_q    <= 1'b0;
			hit_vld_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (cmd.start) begin
				addr_q     <= '0;
				chk_vld_s1 <= 1'b0;
				ff_vld_q   <= 1'b0;
				hit_vld_q  <= 1'b0;
			end else if (cmd.scan_en) begin
				chk_vld_s1 <= issue;
				if (issue) addr_q <= addr_q + CNT_W'(1);
				if (free_now) ff_vld_q <= 1'b1;
				if (hit_now) hit_vld_q <= 1'b1;
			end else begin
				chk_vld_s1 <= 1'b0;
			end
			if (cmd.commit && (req_q.kind == KIND_ERASE_ALL)) vld_q <= '0;
			else if (mem_we) vld_q[mem_waddr] <= 1'b1;
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	assign too_large = (req_q.payload_length > slot_bytes);

	always_comb begin
		rsp_n        = '0;
		rsp_n.status = ST_NOT_FOUND;
		sel_idx      = '0;
		use_addr     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = hit_q;
		mem_wst      = ENT_DEAD;
		case (req_q.kind)
			KIND_LOOKUP: begin
				rsp_n.free_slot_valid = ff_vld_q;
				rsp_n.free_slot       = ff_q;
				if (hit_vld_q) begin
					rsp_n.status = ST_OK;
					sel_idx      = hit_q;
					use_addr     = 1'b1;
				end
			end
			KIND_WRITE: begin
				if (too_large) begin
					rsp_n.status = ST_TOO_LARGE;
				end else begin
					rsp_n.free_slot_valid = ff_vld_q;
					rsp_n.free_slot       = ff_q;
					if (hit_vld_q) begin
						rsp_n.status = ST_OK;
						sel_idx      = hit_q;
						use_addr     = 1'b1;
					end else if (req_q.auto_create && ff_vld_q) begin
						rsp_n.status = ST_CREATED;
						sel_idx      = ff_q;
						use_addr     = 1'b1;
						mem_we       = cmd.commit;
						mem_waddr    = ff_q;
						mem_wst      = ENT_VALID;
					end
				end
			end
			KIND_ERASE: begin
				rsp_n.free_slot_valid = ff_vld_q;
				rsp_n.free_slot       = ff_q;
				if (hit_vld_q) begin
					rsp_n.status = ST_OK;
					sel_idx      = hit_q;
					use_addr     = 1'b1;
					mem_we       = cmd.commit;
				end
			end
			KIND_ERASE_ALL: begin
				rsp_n.status = ST_DONE;
			end
			KIND_READ_IDX: begin
				if (CNT_W'(req_q.slot_number) >= cnt_eff) begin
					rsp_n.status = ST_BAD_INDEX;
				end else begin
					rsp_n.status = ST_OK;
					sel_idx      = req_q.slot_number;
					use_addr     = 1'b1;
				end
			end
			default: ;
		endcase
		rsp_n.slot_index   = sel_idx;
		rsp_n.byte_address = use_addr ? (base_q + (ADDR_W'(sel_idx) << lg)) : '0;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTH
	a_chk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (CNT_W'(chk_idx_s1) < cnt_eff))
		else $error("scan checked a slot beyond the slot count");
	a_free_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && ff_vld_q) |-> (CNT_W'(ff_q) < cnt_eff))
		else $error("free slot beyond the slot count");
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && hit_vld_q) |-> (CNT_W'(hit_q) < cnt_eff))
		else $error("hit slot beyond the slot count");
	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.commit))
		else $error("result raised without a commit");
`endif

endmodule

// ===== hdl/flash_slot_key_directory_unit.sv =====
`timescale 1ns / 1ps

// Flash slot key directory.
// Request channel: req_valid / req_stall / req (fskd_req_t). A beat is taken
// when req_valid is high and req_stall is low. One request is handled at a time.
// Response channel: rsp_valid / rsp_stall / rsp (fskd_rsp_t), one beat per request.
// Lookup, write and erase-by-key scan the directory RAM one slot per cycle,
// stopping at the first hit or after the last configured slot; the response
// is then loaded in the finish state, and the next request is taken from idle.
// Erase-all, read-by-index, rejected writes and scans of zero slots skip the
// scan and go straight to the finish state. A stalled response holds and
// delays loading the next one; a request is taken only once the previous one
// is loaded. Configuration: cfg_we / cfg_index / cfg_wdata, to be written
// only when idle; the block itself does not enforce this.
// Reset clears the configuration to base 0, slot size 256 bytes, 16 slots,
// and marks every slot free at once through per-slot valid bits.
module flash_slot_key_directory_unit import fskd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [ADDR_W-1:0] cfg_wdata,
	input  logic              req_valid,
	output logic              req_stall,
	input  fskd_req_t         req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output fskd_rsp_t         rsp
);

	fskd_cmd_t cmd;
	fskd_sts_t sts;

	fskd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fskd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== verif/tb_flash_slot_key_directory_unit.sv =====
`timescale 1ns / 1ps

module tb_flash_slot_key_directory_unit;
	import fskd_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int POOL_N      = 12;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = CFG_BASE;
	logic [ADDR_W-1:0] cfg_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	fskd_req_t         req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	fskd_rsp_t         rsp;

	flash_slot_key_directory_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// directory shadow
	logic [ENT_W-1:0]  ent_state [MAX_SLOTS];
	logic [KEY_W-1:0]  ent_key   [MAX_SLOTS];
	logic [ADDR_W-1:0] region_base  = '0;
	logic [LOG2_W-1:0] region_log2  = LOG2_W'(8);
	logic [CNT_W-1:0]  region_count = CNT_W'(16);

	fskd_req_t requests_to_send [$];
	fskd_rsp_t slot_results_due [$];
	logic [KEY_W-1:0] key_pool [POOL_N];

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int errors = 0;
	int cycle_cnt = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			ent_state[i] = ENT_FREE;
			ent_key[i] = '0;
		end
	end

	function automatic int unsigned size_log2();
		int unsigned l;
		l = int'(region_log2);
		if (l < 2) l = 2;
		if (l > 12) l = 12;
		while (l > 2 && (1 << l) > SECTOR_BYTES) l--;
		return l;
	endfunction

	function automatic int unsigned live_count();
		return (int'(region_count) > MAX_SLOTS) ? MAX_SLOTS : int'(region_count);
	endfunction

	function automatic fskd_rsp_t directory_predict(fskd_req_t r);
		fskd_rsp_t o;
		int unsigned l, n, hit_idx, ff;
		bit scanned, hit, ff_ok, too_big;
		o = '0;
		o.status = ST_NOT_FOUND;
		l = size_log2();
		n = live_count();
		hit = 0;
		ff_ok = 0;
		ff = 0;
		hit_idx = 0;
		too_big = (r.kind == KIND_WRITE) && (int'(r.payload_length) > (1 << l));
		scanned = (r.kind == KIND_LOOKUP) || (r.kind == KIND_ERASE) ||
			(r.kind == KIND_WRITE && !too_big);
		if (scanned) begin
			for (int unsigned i = 0; i < n && !hit; i++) begin
				if (ent_state[i] == ENT_VALID && ent_key[i] == r.search_key) begin
					hit = 1;
					hit_idx = i;
				end else if (!ff_ok && ent_state[i] == ENT_FREE) begin
					ff_ok = 1;
					ff = i;
				end
			end
		end
		case (r.kind)
			KIND_LOOKUP, KIND_ERASE: begin
				if (hit) begin
					o.status = ST_OK;
					o.slot_index = SLOT_AW'(hit_idx);
					if (r.kind == KIND_ERASE) ent_state[hit_idx] = ENT_DEAD;
				end
			end
			KIND_WRITE: begin
				if (too_big) begin
					o.status = ST_TOO_LARGE;
				end else if (hit) begin
					o.status = ST_OK;
					o.slot_index = SLOT_AW'(hit_idx);
				end else if (r.auto_create && ff_ok) begin
					ent_state[ff] = ENT_VALID;
					ent_key[ff] = r.search_key;
					o.status = ST_CREATED;
					o.slot_index = SLOT_AW'(ff);
				end
			end
			KIND_ERASE_ALL: begin
				for (int i = 0; i < MAX_SLOTS; i++) ent_state[i] = ENT_FREE;
				o.status = ST_DONE;
			end
			KIND_READ_IDX: begin
				if (r.slot_number >= n) begin
					o.status = ST_BAD_INDEX;
				end else begin
					o.status = ST_OK;
					o.slot_index = r.slot_number;
				end
			end
			default: ;
		endcase
		if (o.status == ST_OK || o.status == ST_CREATED)
			o.byte_address = region_base + (ADDR_W'(o.slot_index) << l);
		if (scanned && ff_ok) begin
			o.free_slot_valid = 1'b1;
			o.free_slot = SLOT_AW'(ff);
		end
		return o;
	endfunction

	function automatic fskd_req_t req_of(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key,
		logic [LEN_W-1:0] len, logic ac, logic [SLOT_AW-1:0] num);
		fskd_req_t r;
		r.kind = k;
		r.search_key = key;
		r.payload_length = len;
		r.auto_create = ac;
		r.slot_number = num;
		return r;
	endfunction

	function automatic fskd_req_t random_request();
		fskd_req_t r;
		int unsigned pick, sz, n;
		sz = 1 << size_log2();
		n = live_count();
		pick = $urandom_range(99);
		if (pick < 25) r.kind = KIND_LOOKUP;
		else if (pick < 62) r.kind = KIND_WRITE;
		else if (pick < 78) r.kind = KIND_ERASE;
		else if (pick < 81) r.kind = KIND_ERASE_ALL;
		else if (pick < 96) r.kind = KIND_READ_IDX;
		else r.kind = KIND_W'($urandom_range(int'(KIND_READ_IDX) + 1, (1 << KIND_W) - 1));
		r.search_key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_N - 1)] :
			KEY_W'($urandom());
		pick = $urandom_range(99);
		if (pick < 70) r.payload_length = LEN_W'($urandom_range(sz));
		else if (pick < 80) r.payload_length = LEN_W'(sz);
		else if (pick < 90) r.payload_length = LEN_W'($urandom_range(SECTOR_BYTES, sz + 1));
		else r.payload_length = LEN_W'($urandom());
		r.auto_create = ($urandom_range(99) < 85);
		if (n > 0 && $urandom_range(99) < 60) r.slot_number = SLOT_AW'($urandom_range(n - 1));
		else r.slot_number = SLOT_AW'($urandom());
		return r;
	endfunction

	task automatic drain();
		while (!(requests_to_send.size() == 0 && !req_valid && slot_results_due.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [LOG2_W-1:0] lg,
		input logic [CNT_W-1:0] cnt, input int idle_pct, input int stall_pct, input int n_items);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= CFG_LOG2;
		cfg_wdata <= ADDR_W'(lg);
		@(posedge clk);
		cfg_index <= CFG_COUNT;
		cfg_wdata <= ADDR_W'(cnt);
		@(posedge clk);
		cfg_we <= 1'b0;
		region_base = base;
		region_log2 = lg;
		region_count = cnt;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++) key_pool[i] = KEY_W'($urandom());
		repeat (n_items) requests_to_send.push_back(random_request());
	endtask

	// request driver
	always @(posedge clk) begin
		if (req_valid && !req_stall)
			slot_results_due.push_back(directory_predict(req));
		if (!req_valid || !req_stall) begin
			if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req <= requests_to_send.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response monitor
	always @(posedge clk) begin : rsp_mon
		fskd_rsp_t want;
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		if (rsp_valid && !rsp_stall) begin
			if (slot_results_due.size() == 0) begin
				$error("response beat with nothing outstanding");
				errors++;
			end else begin
				want = slot_results_due.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d", want.slot_index, rsp.slot_index);
					errors++;
				end
				if (rsp.byte_address !== want.byte_address) begin
					$error("byte_address: expected %h, got %h", want.byte_address,
						rsp.byte_address);
					errors++;
				end
				if (rsp.free_slot_valid !== want.free_slot_valid) begin
					$error("free_slot_valid: expected %0d, got %0d", want.free_slot_valid,
						rsp.free_slot_valid);
					errors++;
				end
				if (rsp.free_slot !== want.free_slot) begin
					$error("free_slot: expected %0d, got %0d", want.free_slot, rsp.free_slot);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_flash_slot_key_directory_unit failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: base 0, 256-byte slots, 16 slots
		requests_to_send.push_back(req_of(KIND_LOOKUP, 16'h1234, 13'd0, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_WRITE, 16'h0000, 13'd257, 1'b1, 8'd0));
		requests_to_send.push_back(req_of(KIND_WRITE, 16'h0000, 13'd256, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_WRITE, 16'h0000, 13'd256, 1'b1, 8'd0));
		requests_to_send.push_back(req_of(KIND_WRITE, 16'hFFFF, 13'd0, 1'b1, 8'd0));
		requests_to_send.push_back(req_of(KIND_LOOKUP, 16'hFFFF, 13'd0, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_WRITE, 16'hFFFF, 13'd100, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_ERASE, 16'h0000, 13'd0, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_LOOKUP, 16'h0000, 13'd0, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_WRITE, 16'h0000, '1, 1'b1, 8'd0));
		requests_to_send.push_back(req_of(KIND_WRITE, 16'h0000, 13'd1, 1'b1, 8'd0));
		requests_to_send.push_back(req_of(KIND_ERASE, 16'hABCD, 13'd0, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_READ_IDX, 16'h0000, 13'd0, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_READ_IDX, 16'h0000, 13'd0, 1'b0, 8'd15));
		requests_to_send.push_back(req_of(KIND_READ_IDX, 16'h0000, 13'd0, 1'b0, 8'd16));
		requests_to_send.push_back(req_of(KIND_READ_IDX, '1, '1, 1'b1, '1));
		for (int k = int'(KIND_READ_IDX) + 1; k < (1 << KIND_W); k++)
			requests_to_send.push_back(req_of(KIND_W'(k), '1, '1, 1'b1, '1));
		requests_to_send.push_back(req_of(KIND_ERASE_ALL, 16'h0000, 13'd0, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_LOOKUP, 16'hFFFF, 13'd0, 1'b0, 8'd0));
		requests_to_send.push_back(req_of(KIND_WRITE, 16'h5A5A, 13'd0, 1'b1, 8'd0));

		run_phase(32'hFFFF_FFF0, 4'd2, 9'd8, 0, 0, 200);
		run_phase($urandom(), 4'd12, 9'd1, 72, 0, 150);
		run_phase($urandom(), 4'd15, 9'd37, 0, 72, 200);
		run_phase(32'hFFFF_FFFF, 4'd0, 9'd0, 7, 7, 60);
		run_phase($urandom(), 4'd5, 9'd256, 0, 0, 80);
		run_phase($urandom(), 4'd11, 9'd511, 7, 7, 60);
		run_phase($urandom(), 4'd9, 9'd20, 72, 0, 200);
		run_phase($urandom(), LOG2_W'($urandom_range(15)), 9'd12, 0, 72, 300);

		drain();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb_flash_slot_key_directory_unit passed");
		else
			$display("tb_flash_slot_key_directory_unit failed");
		$finish;
	end

endmodule
